@@ rtl/line_color_gap_fill_scanline_core_assert.svh @@
// Assertion macros for the scanline gap filler.
// Used by the top level; expects aclk and aresetn in the enclosing module.
`ifndef LINE_COLOR_GAP_FILL_SCANLINE_CORE_ASSERT_SVH
`define LINE_COLOR_GAP_FILL_SCANLINE_CORE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define LCGF_ASSERT_IMP(name, cond, prop, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |-> (prop)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define LCGF_ASSERT_NXT(name, cond, prop, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |=> (prop)) \
        else $error(msg);

`endif

@@ rtl/lcgf_pkg.sv @@
// Shared types and constants of the scanline gap filler.
// No dependencies; used by every module of the block.
package lcgf_pkg;

    localparam int SEARCH_REACH    = 20;
    localparam int MAX_LINE_LENGTH = 4096;
    localparam int NUM_LINE_COLORS = 4;

    // Window geometry: the pixel under decision sits in the middle cell.
    localparam int AHEAD     = SEARCH_REACH - 1;
    localparam int WIN_DEPTH = 2 * AHEAD + 1;
    localparam int CENTER    = AHEAD;

    localparam int POS_W     = $clog2(MAX_LINE_LENGTH);
    localparam int FLUSH_W   = $clog2(AHEAD + 1);
    localparam int LEVEL_W   = 10;
    localparam int TALLY_W   = 13;
    localparam int TALLY_MAX = (1 << TALLY_W) - 1;
    localparam int PIXEL_W   = 32;
    localparam int NUM_COLOR_REGS = 4;
    localparam int CFG_IDX_W = 3;
    localparam int COUNT_W   = 3;

    typedef enum logic [1:0] {
        CL_CLEAR  = 2'd0,
        CL_WHITE  = 2'd1,
        CL_TARGET = 2'd2,
        CL_USE    = 2'd3
    } cls_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_COLOR_A     = 3'd0,
        REG_COLOR_B     = 3'd1,
        REG_COLOR_C     = 3'd2,
        REG_COLOR_D     = 3'd3,
        REG_COLOR_COUNT = 3'd4,
        REG_PREFER_DARK = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic               valid;
        cls_t               cls;
        logic [LEVEL_W-1:0] level;
        logic [PIXEL_W-1:0] pixel;
    } cell_t;

    typedef struct packed {
        logic [PIXEL_W-1:0] pixel;
        logic               unres;
        logic               done;
    } pick_t;

endpackage

@@ rtl/line_color_gap_fill_scanline_core.sv @@
// Scanline line-color gap filler. Pixels of a scanline stream in one per clock;
// each is classified on entry (transparent, white, line color, usable) and
// shifted into a chain of 39 cells. The pixel in the middle cell is decided
// with 19 cells of context on each side, so its result can leave only after
// the pixel 19 positions later is taken. Inside a line the block takes one
// pixel per clock and returns one result per clock while the output is ready.
// After the last pixel of a line (end_of_line, or the 4096th pixel) the input
// is held off while the chain drains the tail of the line, waiting whenever
// the output stalls; these 19 empty cells also separate the line from the
// next one. unresolved_count is nonzero only on the result beat that carries
// line_done.
`include "line_color_gap_fill_scanline_core_assert.svh"

module line_color_gap_fill_scanline_core (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_in_alpha,
    input  logic [7:0]  s_in_red,
    input  logic [7:0]  s_in_green,
    input  logic [7:0]  s_in_blue,
    input  logic        s_end_of_line,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_alpha,
    output logic [7:0]  m_out_red,
    output logic [7:0]  m_out_green,
    output logic [7:0]  m_out_blue,
    output logic        m_line_done,
    output logic [12:0] m_unresolved_count,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int D = lcgf_pkg::WIN_DEPTH;

    // Configuration registers. The user must change them only while the block is idle; the block does not enforce this.
    logic [lcgf_pkg::PIXEL_W-1:0] color_reg [lcgf_pkg::NUM_COLOR_REGS];
    logic [lcgf_pkg::COUNT_W-1:0] color_count_reg;
    logic                         prefer_dark_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < lcgf_pkg::NUM_COLOR_REGS; k++) begin
                color_reg[k] <= '0;
            end
            color_count_reg <= '0;
            prefer_dark_reg <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                lcgf_pkg::REG_COLOR_A:     color_reg[0] <= cfg_data;
                lcgf_pkg::REG_COLOR_B:     color_reg[1] <= cfg_data;
                lcgf_pkg::REG_COLOR_C:     color_reg[2] <= cfg_data;
                lcgf_pkg::REG_COLOR_D:     color_reg[3] <= cfg_data;
                lcgf_pkg::REG_COLOR_COUNT: color_count_reg <= cfg_data[lcgf_pkg::COUNT_W-1:0];
                lcgf_pkg::REG_PREFER_DARK: prefer_dark_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Classification of the incoming pixel. A color count above the number
    // of supported line colors is clamped.
    logic [lcgf_pkg::PIXEL_W-1:0] in_pixel;
    logic [lcgf_pkg::COUNT_W-1:0] color_limit;
    logic                         color_hit;
    lcgf_pkg::cell_t              in_cell;

    assign in_pixel = {s_in_alpha, s_in_red, s_in_green, s_in_blue};
    assign color_limit =
        (color_count_reg > lcgf_pkg::COUNT_W'(lcgf_pkg::NUM_LINE_COLORS))
            ? lcgf_pkg::COUNT_W'(lcgf_pkg::NUM_LINE_COLORS) : color_count_reg;

    always_comb begin
        color_hit = 1'b0;
        for (int j = 0; j < lcgf_pkg::NUM_LINE_COLORS; j++) begin
            if ((lcgf_pkg::COUNT_W'(j) < color_limit) && (color_reg[j] == in_pixel)) begin
                color_hit = 1'b1;
            end
        end
    end

    always_comb begin
        in_cell.valid = 1'b1;
        in_cell.pixel = in_pixel;
        in_cell.level = '0;
        if (s_in_alpha == 8'd0) begin
            in_cell.cls   = lcgf_pkg::CL_CLEAR;
            in_cell.pixel = '0;
        end else if ({s_in_red, s_in_green, s_in_blue} == 24'hFFFFFF) begin
            in_cell.cls = lcgf_pkg::CL_WHITE;
        end else if (color_hit) begin
            in_cell.cls = lcgf_pkg::CL_TARGET;
        end else begin
            in_cell.cls   = lcgf_pkg::CL_USE;
            in_cell.level = lcgf_pkg::LEVEL_W'(s_in_red) + lcgf_pkg::LEVEL_W'(s_in_green)
                          + lcgf_pkg::LEVEL_W'(s_in_blue);
        end
    end

    // Control: a step shifts the chain by one, either with an accepted pixel
    // or, while draining the end of a line, with an empty cell. pend_reg
    // marks a middle cell that still owes its result; a step may only occur
    // when that result moves into the output register in the same cycle.
    logic [lcgf_pkg::POS_W-1:0]   pos_reg, pos_next;
    logic [lcgf_pkg::FLUSH_W-1:0] flush_cnt_reg, flush_cnt_next;
    logic                         pend_reg, pend_next;
    logic                         flush_active, step_ok, step, in_accept, in_last, out_load;
    lcgf_pkg::cell_t              shift_in;
    lcgf_pkg::cell_t              win [D];
    lcgf_pkg::pick_t              pick;

    assign flush_active = (flush_cnt_reg != '0);
    assign out_load     = pend_reg && (!m_valid || m_ready);
    assign step_ok      = !pend_reg || out_load;
    assign s_ready      = !flush_active && step_ok;
    assign in_accept    = s_valid && s_ready;
    assign step         = in_accept || (flush_active && step_ok);
    assign in_last      = s_end_of_line
                       || (pos_reg == lcgf_pkg::POS_W'(lcgf_pkg::MAX_LINE_LENGTH - 1));

    always_comb begin
        shift_in       = in_cell;
        shift_in.valid = in_accept;
    end

    always_comb begin
        pos_next       = pos_reg;
        flush_cnt_next = flush_cnt_reg;
        pend_next      = pend_reg;
        if (in_accept) begin
            pos_next = in_last ? '0 : pos_reg + lcgf_pkg::POS_W'(1);
            if (in_last) begin
                flush_cnt_next = lcgf_pkg::FLUSH_W'(lcgf_pkg::AHEAD);
            end
        end else if (step) begin
            flush_cnt_next = flush_cnt_reg - lcgf_pkg::FLUSH_W'(1);
        end
        if (step) begin
            pend_next = win[lcgf_pkg::CENTER-1].valid;
        end else if (out_load) begin
            pend_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg       <= '0;
            flush_cnt_reg <= '0;
            pend_reg      <= 1'b0;
        end else begin
            pos_reg       <= pos_next;
            flush_cnt_reg <= flush_cnt_next;
            pend_reg      <= pend_next;
        end
    end

    // The window: cell 0 holds the newest pixel, each step moves every
    // pixel one cell further along.
    for (genvar k = 0; k < D; k++) begin : g_chain
        if (k == 0) begin : g_head
            lcgf_cell u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .shift_en (step),
                .d        (shift_in),
                .q        (win[k])
            );
        end else begin : g_body
            lcgf_cell u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .shift_en (step),
                .d        (win[k-1]),
                .q        (win[k])
            );
        end
    end

    lcgf_pick u_pick (
        .win         (win),
        .prefer_dark (prefer_dark_reg),
        .res         (pick)
    );

    // Output register and the unresolved tally of the current line.
    logic                         m_valid_reg, m_valid_next;
    logic [lcgf_pkg::PIXEL_W-1:0] m_pixel_reg;
    logic                         m_done_reg;
    logic [lcgf_pkg::TALLY_W-1:0] m_count_reg;
    logic [lcgf_pkg::TALLY_W-1:0] tally_reg, tally_next, tally_bumped;

    assign tally_bumped = (pick.unres && (tally_reg != lcgf_pkg::TALLY_W'(lcgf_pkg::TALLY_MAX)))
                        ? tally_reg + lcgf_pkg::TALLY_W'(1) : tally_reg;

    always_comb begin
        m_valid_next = m_valid_reg;
        tally_next   = tally_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
            tally_next   = pick.done ? '0 : tally_bumped;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            tally_reg   <= '0;
        end else begin
            m_valid_reg <= m_valid_next;
            tally_reg   <= tally_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_pixel_reg <= pick.pixel;
            m_done_reg  <= pick.done;
            m_count_reg <= pick.done ? tally_bumped : '0;
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_out_alpha        = m_pixel_reg[31:24];
    assign m_out_red          = m_pixel_reg[23:16];
    assign m_out_green        = m_pixel_reg[15:8];
    assign m_out_blue         = m_pixel_reg[7:0];
    assign m_line_done        = m_done_reg;
    assign m_unresolved_count = m_count_reg;

    `LCGF_ASSERT_IMP(a_step_drains_pending, step && pend_reg, out_load,
        "chain shifted while the middle cell still owed its result")
    `LCGF_ASSERT_IMP(a_pending_is_pixel, pend_reg, win[lcgf_pkg::CENTER].valid,
        "pending result points at an empty middle cell")
    `LCGF_ASSERT_NXT(a_last_starts_drain, in_accept && in_last,
        flush_cnt_reg == lcgf_pkg::FLUSH_W'(lcgf_pkg::AHEAD),
        "end of line did not start the drain")
    `LCGF_ASSERT_IMP(a_count_only_on_done, m_valid && !m_line_done, m_unresolved_count == '0,
        "unresolved count shown on a beat that does not end the line")

endmodule

@@ rtl/lcgf_cell.sv @@
// One cell of the pixel window chain: holds a classified pixel and passes it on.
// Depends on lcgf_pkg.
module lcgf_cell (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           shift_en,
    input  lcgf_pkg::cell_t d,
    output lcgf_pkg::cell_t q
);

    logic                        valid_reg;
    lcgf_pkg::cls_t              cls_reg;
    logic [lcgf_pkg::LEVEL_W-1:0] level_reg;
    logic [lcgf_pkg::PIXEL_W-1:0] pixel_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (shift_en) begin
            valid_reg <= d.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            cls_reg   <= d.cls;
            level_reg <= d.level;
            pixel_reg <= d.pixel;
        end
    end

    assign q = '{valid: valid_reg, cls: cls_reg, level: level_reg, pixel: pixel_reg};

endmodule

@@ rtl/lcgf_pick.sv @@
// Replacement decision for the pixel in the middle cell of the window.
// Depends on lcgf_pkg; reads every cell of the chain.
module lcgf_pick (
    input  lcgf_pkg::cell_t win [lcgf_pkg::WIN_DEPTH],
    input  logic            prefer_dark,
    output lcgf_pkg::pick_t res
);

    localparam int C = lcgf_pkg::CENTER;

    logic                         ul, ur, first_px, last_px, take_left;
    logic                         far_r_found, far_l_found;
    logic [lcgf_pkg::PIXEL_W-1:0] far_r_pixel, far_l_pixel;
    logic [lcgf_pkg::LEVEL_W-1:0] far_r_level, far_l_level;

    // Nearest usable pixel on either side, two to AHEAD cells away.
    // Scanning from far to near lets the nearest hit win.
    always_comb begin
        far_r_found = 1'b0;
        far_r_pixel = '0;
        far_r_level = '0;
        far_l_found = 1'b0;
        far_l_pixel = '0;
        far_l_level = '0;
        for (int t = lcgf_pkg::AHEAD; t >= 2; t--) begin
            if (win[C-t].valid && (win[C-t].cls == lcgf_pkg::CL_USE)) begin
                far_r_found = 1'b1;
                far_r_pixel = win[C-t].pixel;
                far_r_level = win[C-t].level;
            end
            if (win[C+t].valid && (win[C+t].cls == lcgf_pkg::CL_USE)) begin
                far_l_found = 1'b1;
                far_l_pixel = win[C+t].pixel;
                far_l_level = win[C+t].level;
            end
        end
    end

    assign ul       = win[C+1].valid && (win[C+1].cls == lcgf_pkg::CL_USE);
    assign ur       = win[C-1].valid && (win[C-1].cls == lcgf_pkg::CL_USE);
    assign first_px = !win[C+1].valid;
    assign last_px  = !win[C-1].valid;

    always_comb begin
        res.pixel = win[C].pixel;
        res.unres = 1'b0;
        res.done  = last_px;
        take_left = 1'b0;
        if (win[C].cls == lcgf_pkg::CL_TARGET) begin
            if (first_px && last_px) begin
                res.unres = 1'b1;
            end else if (first_px) begin
                if (ur) res.pixel = win[C-1].pixel;
                else    res.unres = 1'b1;
            end else if (last_px) begin
                if (ul) res.pixel = win[C+1].pixel;
                else    res.unres = 1'b1;
            end else if (ul && ur) begin
                // Darker neighbor wins; a tie goes to the right.
                res.pixel = (win[C+1].level < win[C-1].level) ? win[C+1].pixel
                                                              : win[C-1].pixel;
            end else if (!ul && !ur) begin
                res.unres = 1'b1;
            end else if (ul) begin
                if (far_r_found) begin
                    take_left = prefer_dark ? (win[C+1].level <= far_r_level)
                                            : (win[C+1].level >= far_r_level);
                    res.pixel = take_left ? win[C+1].pixel : far_r_pixel;
                end else begin
                    res.pixel = win[C+1].pixel;
                end
            end else begin
                if (far_l_found) begin
                    take_left = prefer_dark ? (far_l_level <= win[C-1].level)
                                            : (far_l_level >= win[C-1].level);
                    res.pixel = take_left ? far_l_pixel : win[C-1].pixel;
                end else begin
                    res.pixel = win[C-1].pixel;
                end
            end
        end
    end

endmodule
